### hdl/cbd_pkg.sv
// Shared types and constants for the charger status blink detector.
package cbd_pkg;

    // Widths of the request, result and configuration fields.
    localparam int unsigned TS_W     = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Register reset values.
    localparam logic [MS_W-1:0]  MIN_HALF_RST  = 16'd300;
    localparam logic [MS_W-1:0]  MAX_HALF_RST  = 16'd600;
    localparam logic [CNT_W-1:0] PULSES_RST    = 4'd3;
    localparam logic [MS_W-1:0]  TIMEOUT_RST   = 16'd600;

    // Reported charger status codes.
    typedef enum logic [1:0] {
        ST_INIT     = 2'd0,
        ST_CHARGING = 2'd1,
        ST_DONE     = 2'd2,
        ST_FAULT    = 2'd3
    } t_status;

    // Request kinds.
    typedef enum logic {
        CMD_EDGE = 1'b0,
        CMD_POLL = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_HALF = 2'd0,
        CFG_MAX_HALF = 2'd1,
        CFG_PULSES   = 2'd2,
        CFG_TIMEOUT  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [MS_W-1:0]  min_half_period_ms;
        logic [MS_W-1:0]  max_half_period_ms;
        logic [CNT_W-1:0] pulses_for_fault;
        logic [MS_W-1:0]  blink_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic             cmd;
        logic [TS_W-1:0]  now_ms;
        logic             pin_level;
    } t_item;

    typedef struct packed {
        logic [1:0] charge_status;
        logic       blinking;
    } t_result;

endpackage

### hdl/cbd_req_if.sv
// Request channel carrying pin edge events and status polls.
interface cbd_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] now_ms;
    logic        pin_level;

    modport source (output valid, output cmd, output now_ms, output pin_level, input ready);
    modport sink   (input valid, input cmd, input now_ms, input pin_level, output ready);
endinterface

### hdl/cbd_rsp_if.sv
// Result channel carrying the charger status after each request.
interface cbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] charge_status;
    logic       blinking;

    modport source (output valid, output charge_status, output blinking, input ready);
    modport sink   (input valid, input charge_status, input blinking, output ready);
endinterface

### hdl/cbd_core.sv
// Blink classification state and its per-request update.
module cbd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbd_pkg::t_cfg   i_cfg,
    input  logic            i_step,
    input  cbd_pkg::t_item  i_item,
    output cbd_pkg::t_result o_result
);
    import cbd_pkg::*;

    logic [TS_W-1:0]  r_last_edge, n_last_edge;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_blink, n_blink;
    logic [1:0]       r_status, n_status;

    logic [TS_W-1:0]  delta;
    logic             in_window;
    logic             timed_out;
    logic [CNT_W-1:0] cnt_inc;

    // Interval since the last edge, modulo 2^32, and the window tests.
    assign delta     = i_item.now_ms - r_last_edge;
    assign in_window = (delta >= {{(TS_W-MS_W){1'b0}}, i_cfg.min_half_period_ms}) &&
                       (delta <= {{(TS_W-MS_W){1'b0}}, i_cfg.max_half_period_ms});
    assign timed_out = r_blink &&
                       (delta > {{(TS_W-MS_W){1'b0}}, i_cfg.blink_timeout_ms});
    // The pulse count saturates at the threshold.
    assign cnt_inc   = (r_cnt < i_cfg.pulses_for_fault) ? r_cnt + 1'b1 : r_cnt;

    // Next state for the request now in the input register.
    always_comb begin
        n_last_edge = r_last_edge;
        n_cnt       = r_cnt;
        n_blink     = r_blink;
        n_status    = r_status;
        if (i_item.cmd == CMD_EDGE) begin
            n_last_edge = i_item.now_ms;
            if (in_window) begin
                n_cnt = cnt_inc;
                if (cnt_inc >= i_cfg.pulses_for_fault) begin
                    n_blink  = 1'b1;
                    n_status = ST_FAULT;
                end
            end else begin
                n_cnt    = '0;
                n_blink  = 1'b0;
                n_status = i_item.pin_level ? ST_DONE : ST_CHARGING;
            end
        end else if (timed_out) begin
            n_cnt    = '0;
            n_blink  = 1'b0;
            n_status = i_item.pin_level ? ST_DONE : ST_CHARGING;
        end
    end

    // State registers advance once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_cnt       <= '0;
            r_blink     <= 1'b0;
            r_status    <= ST_INIT;
        end else if (i_step) begin
            r_last_edge <= n_last_edge;
            r_cnt       <= n_cnt;
            r_blink     <= n_blink;
            r_status    <= n_status;
        end
    end

    assign o_result.charge_status = n_status;
    assign o_result.blinking      = n_blink;

endmodule

### hdl/charger_status_blink_detector.sv
// Top level of the charger status blink detector.
//
// Each request (a pin edge event or a status poll) gives exactly one result
// with the charger status and the blinking flag as they stand after it. The
// block takes one request per clock cycle while results are taken. A request
// is held in the input register while the combinational state update runs,
// and its result is then loaded into the result register, from which it is
// offered. A result that is not taken keeps the result register full; with
// both registers full the request side stalls until the result is taken.
// Configuration registers are written through a plain write port and should
// only be changed while no request is in flight.
module charger_status_blink_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cbd_req_if.sink                        i_req,
    cbd_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cbd_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import cbd_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_result core_result;
    logic    step;
    logic    in_ready;
    logic    in_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_half_period_ms <= MIN_HALF_RST;
            r_cfg.max_half_period_ms <= MAX_HALF_RST;
            r_cfg.pulses_for_fault   <= PULSES_RST;
            r_cfg.blink_timeout_ms   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_HALF: r_cfg.min_half_period_ms <= i_cfg_data[MS_W-1:0];
                CFG_MAX_HALF: r_cfg.max_half_period_ms <= i_cfg_data[MS_W-1:0];
                CFG_PULSES:   r_cfg.pulses_for_fault   <= i_cfg_data[CNT_W-1:0];
                CFG_TIMEOUT:  r_cfg.blink_timeout_ms   <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: a request moves on when the result register is free or drains.
    assign step      = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign in_ready  = !r_in_vld || step;
    assign in_accept = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.cmd       <= i_req.cmd;
            r_in.now_ms    <= i_req.now_ms;
            r_in.pin_level <= i_req.pin_level;
        end
    end

    cbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.charge_status = r_out.charge_status;
    assign o_rsp.blinking      = r_out.blinking;

endmodule

### hdl/cbd_chk.sv
// Port-level checks for the charger status blink detector, bound to the top level.
module cbd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic       i_rsp_blinking
);
    import cbd_pkg::*;

    // Reset empties the pipeline: no result is offered right after it.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // Reset leaves the block ready to take a request.
    a_reset_ready : assert property (@(posedge i_clk)
        !i_rst_n |=> i_req_ready)
        else $error("request side not ready after reset");

    // The blinking flag is only ever reported together with the fault status.
    a_blink_fault : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_blinking |-> i_rsp_status == ST_FAULT)
        else $error("blinking reported without fault status");

    // A stalled result holds its value.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_blinking))
        else $error("stalled result changed");

endmodule

bind charger_status_blink_detector cbd_chk u_cbd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.charge_status),
    .i_rsp_blinking (o_rsp.blinking)
);

### tb/sv/cbd_status_checker.sv
// Checker that predicts and compares every result of the charger status blink detector.
module cbd_status_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cbd_req_if                            i_req,
    cbd_rsp_if                            i_rsp,
    input  logic                          i_cfg_we,
    input  logic [cbd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbd_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int unsigned                   o_fail_count,
    output int unsigned                   o_pending
);
    import cbd_pkg::*;

    // Shadow copy of the thresholds and of the detector state.
    t_cfg             cfg;
    logic [TS_W-1:0]  last_edge_ms;
    logic [CNT_W-1:0] pulse_cnt;
    logic             blink;
    t_status          status;

    // Expected results, oldest first.
    t_result status_q[$];

    // Drops the blink pattern and lets the status follow the pin level.
    function automatic void clear_to_pin(logic level);
        pulse_cnt = '0;
        blink     = 1'b0;
        status    = level ? ST_DONE : ST_CHARGING;
    endfunction

    // Applies one request to the shadow state and returns the status after it.
    function automatic t_result advance_status(logic kind, logic [TS_W-1:0] stamp,
                                               logic level);
        logic [TS_W-1:0] gap;
        t_result         r;
        gap = stamp - last_edge_ms;
        if (kind == CMD_EDGE) begin
            last_edge_ms = stamp;
            if (gap >= cfg.min_half_period_ms && gap <= cfg.max_half_period_ms) begin
                // The count saturates at the threshold.
                if (pulse_cnt < cfg.pulses_for_fault)
                    pulse_cnt = pulse_cnt + 1'b1;
                if (pulse_cnt >= cfg.pulses_for_fault) begin
                    blink  = 1'b1;
                    status = ST_FAULT;
                end
            end else begin
                clear_to_pin(level);
            end
        end else if (blink && gap > cfg.blink_timeout_ms) begin
            clear_to_pin(level);
        end
        r.charge_status = status;
        r.blinking      = blink;
        return r;
    endfunction

    // Results are compared before new requests are queued, so a stray result
    // can never be matched against a request of the same cycle.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg.min_half_period_ms = MIN_HALF_RST;
            cfg.max_half_period_ms = MAX_HALF_RST;
            cfg.pulses_for_fault   = PULSES_RST;
            cfg.blink_timeout_ms   = TIMEOUT_RST;
            last_edge_ms           = '0;
            pulse_cnt              = '0;
            blink                  = 1'b0;
            status                 = ST_INIT;
            status_q.delete();
            o_fail_count           = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (status_q.size() == 0) begin
                    $error("unexpected result: charge_status %0d blinking %0d",
                           i_rsp.charge_status, i_rsp.blinking);
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    if (i_rsp.charge_status !== want.charge_status) begin
                        $error("charge_status mismatch: expected %0d, actual %0d",
                               want.charge_status, i_rsp.charge_status);
                        o_fail_count++;
                    end
                    if (i_rsp.blinking !== want.blinking) begin
                        $error("blinking mismatch: expected %0d, actual %0d",
                               want.blinking, i_rsp.blinking);
                        o_fail_count++;
                    end
                end
            end

            // Register writes take effect from the next request.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_HALF: cfg.min_half_period_ms = i_cfg_data;
                    CFG_MAX_HALF: cfg.max_half_period_ms = i_cfg_data;
                    CFG_PULSES:   cfg.pulses_for_fault   = i_cfg_data[CNT_W-1:0];
                    CFG_TIMEOUT:  cfg.blink_timeout_ms   = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_req.valid && i_req.ready)
                status_q.push_back(advance_status(i_req.cmd, i_req.now_ms, i_req.pin_level));
        end
        o_pending = status_q.size();
    end

endmodule

### tb/sv/tb_charger_status_blink_detector.sv
// Top of the testbench: clock, reset, request stimulus, result back-pressure and verdict.
module tb_charger_status_blink_detector;
    import cbd_pkg::*;

    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;

    // Sender and receiver behavior.
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_go      = 1'b0;
    bit          hold_seen    = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned idle_cycles  = 0;

    // Stimulus bookkeeping: last edge time sent and the thresholds in force.
    logic [TS_W-1:0] last_edge_sent = '0;
    int unsigned     req_sent       = 0;
    int unsigned     cur_min        = MIN_HALF_RST;
    int unsigned     cur_max        = MAX_HALF_RST;
    int unsigned     cur_pulses     = PULSES_RST;
    int unsigned     cur_timeout    = TIMEOUT_RST;

    cbd_req_if req_ch ();
    cbd_rsp_if rsp_ch ();

    charger_status_blink_detector dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cbd_status_checker status_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off whenever hold_go toggles.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_go != hold_seen) begin
            hold_seen    <= hold_go;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: ends the run when no request and no result moves for too long.
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request, with random sender gaps, and waits until it is taken.
    task automatic send_req(t_cmd kind, logic [TS_W-1:0] stamp, logic level);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= kind;
        req_ch.now_ms    <= stamp;
        req_ch.pin_level <= level;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        if (kind == CMD_EDGE)
            last_edge_sent = stamp;
        req_sent++;
    endtask

    task automatic edge_after(logic [TS_W-1:0] span, logic level);
        send_req(CMD_EDGE, last_edge_sent + span, level);
    endtask

    task automatic poll_after(logic [TS_W-1:0] span, logic level);
        send_req(CMD_POLL, last_edge_sent + span, level);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Writes all four thresholds back to back; only called while idle.
    task automatic program_thresholds(int unsigned lo, int unsigned hi,
                                      int unsigned pulses, int unsigned tmo);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MIN_HALF;
        cfg_data <= CFG_DAT_W'(lo);
        @(posedge clk);
        cfg_idx  <= CFG_MAX_HALF;
        cfg_data <= CFG_DAT_W'(hi);
        @(posedge clk);
        cfg_idx  <= CFG_PULSES;
        cfg_data <= CFG_DAT_W'(pulses);
        @(posedge clk);
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= CFG_DAT_W'(tmo);
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_min     = lo;
        cur_max     = hi;
        cur_pulses  = pulses;
        cur_timeout = tmo;
    endtask

    // One random step: mostly blink trains, then window misses, polls and noise.
    task automatic random_req();
        int unsigned     pick;
        int unsigned     burst;
        logic [TS_W-1:0] span;
        pick = $urandom_range(99);
        if (pick < 55) begin
            // Now and then a train long enough to reach the fault threshold.
            burst = ($urandom_range(5) == 0) ? cur_pulses + 1 : 1;
            repeat (burst) begin
                if (cur_min <= cur_max)
                    span = cur_min + $urandom_range(cur_max - cur_min);
                else
                    span = $urandom_range(65535);
                edge_after(span, 1'($urandom_range(1)));
            end
        end else if (pick < 68) begin
            case ($urandom_range(2))
                0:       span = cur_min - 1;
                1:       span = cur_max + 1;
                default: span = $urandom;
            endcase
            edge_after(span, 1'($urandom_range(1)));
        end else if (pick < 88) begin
            // Polls around the timeout boundary.
            case ($urandom_range(2))
                0:       span = cur_timeout;
                1:       span = cur_timeout + 1;
                default: span = $urandom_range(2 * cur_timeout + 2);
            endcase
            poll_after(span, 1'($urandom_range(1)));
        end else begin
            send_req(t_cmd'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
        end
    endtask

    // One setting of the thresholds with its own sender and receiver behavior.
    // Under squeeze the receiver holds off while requests keep coming, and the
    // sender pauses halfway until every result is back.
    task automatic run_phase(int unsigned lo, int unsigned hi, int unsigned pulses,
                             int unsigned tmo, int unsigned n, int unsigned tx_pct,
                             int unsigned rx_pct, bit squeeze);
        int unsigned first;
        bit          paused;
        program_thresholds(lo, hi, pulses, tmo);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        if (squeeze)
            hold_go <= ~hold_go;
        first  = req_sent;
        paused = 1'b0;
        last_edge_sent = $urandom;
        while (req_sent - first < n) begin
            if (squeeze && !paused && req_sent - first >= n / 2) begin
                paused = 1'b1;
                settle();
            end
            random_req();
        end
        settle();
    endtask

    initial begin
        int unsigned lo;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_EDGE;
        req_ch.now_ms    = '0;
        req_ch.pin_level = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the reset thresholds (300..600, 3 pulses, 600).
        send_req(CMD_POLL, '0, 1'b1);          // a poll leaves the init state alone
        edge_after(0, 1'b1);                   // zero interval: status follows a high pin
        edge_after(299, 1'b0);                 // just below the window
        edge_after(300, 1'b1);                 // lower bound counts
        edge_after(600, 1'b0);                 // upper bound counts
        edge_after(301, 1'b1);                 // third pulse declares the fault
        edge_after(450, 1'b0);                 // count stays saturated
        poll_after(600, 1'b1);                 // exactly at the timeout: still blinking
        poll_after(601, 1'b1);                 // timeout passed: back to the pin
        edge_after(601, 1'b0);                 // just above the window
        send_req(CMD_EDGE, 32'hFFFF_FF00, 1'b1);
        edge_after(32'h0000_01AC, 1'b0);       // interval across the timestamp wrap
        edge_after(596, 1'b1);
        edge_after(512, 1'b0);
        send_req(CMD_POLL, 32'hFFFF_FFFF, 1'b0);
        send_req(CMD_POLL, '0, 1'b1);          // poll while not blinking
        send_req(CMD_EDGE, 32'hFFFF_FFFF, 1'b1);
        edge_after(300, 1'b0);
        edge_after(301, 1'b1);
        edge_after(599, 1'b0);
        poll_after(599, 1'b0);
        poll_after(32'hFFFF_FFFF, 1'b1);       // poll timestamp behind the last edge
        edge_after(5000, 1'b0);
        settle();

        // Random phases over several threshold settings, the extremes among them.
        run_phase(300, 600, 3, 600, 60, 46, 0, 1'b0);
        run_phase(0, 65535, 15, 65535, 60, 0, 46, 1'b0);
        run_phase(0, 0, 0, 0, 50, 12, 12, 1'b0);
        run_phase(65535, 0, 7, 1000, 50, 0, 0, 1'b0);
        run_phase(65535, 65535, 1, 65535, 50, 46, 0, 1'b0);
        run_phase(20, 40, 2, 30, 60, 0, 46, 1'b0);
        repeat (3) begin
            lo = $urandom_range(1500);
            run_phase(lo, lo + $urandom_range(1500), $urandom_range(15, 1),
                      $urandom_range(65535), 50, 12, 12, 1'b0);
        end
        run_phase(100, 200, 4, 150, 60, 0, 0, 1'b1);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
hdl/cbd_pkg.sv
hdl/cbd_req_if.sv
hdl/cbd_rsp_if.sv
hdl/cbd_core.sv
hdl/charger_status_blink_detector.sv
hdl/cbd_chk.sv
tb/sv/cbd_status_checker.sv
tb/sv/tb_charger_status_blink_detector.sv
